// ===== design/ctsc_pkg.sv =====
`timescale 1ns / 1ps

package ctsc_pkg;

  localparam int MAX_COLUMN = 64;
  localparam int DATA_WIDTH = 32;
  localparam int WEIGHT_W   = 32;
  localparam int FRAC_W     = 30;
  localparam int LEN_W      = 7;
  localparam int ROW_W      = 6;
  localparam int IDX_W      = $clog2(MAX_COLUMN);
  localparam int CNT_W      = $clog2(MAX_COLUMN + 1);
  localparam int PROD_W     = DATA_WIDTH + WEIGHT_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  typedef struct packed {
    logic valid;
    logic im;
  } mul_tag_t;

  typedef struct packed {
    data_t   y_re;
    data_t   y_im;
    weight_t w;
  } store_entry_t;

  function automatic data_t sat_sub(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] diff;
    data_t result;
    diff = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (diff[DATA_WIDTH] != diff[DATA_WIDTH-1]) begin
      result = diff[DATA_WIDTH] ? DMIN : DMAX;
    end else begin
      result = diff[DATA_WIDTH-1:0];
    end
    return result;
  endfunction

endpackage

// ===== design/ctsc_ifs.sv =====
`timescale 1ns / 1ps

interface ctsc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [31:0]                rhs_re;
  logic signed [31:0]                rhs_im;
  logic signed [ctsc_pkg::WEIGHT_W-1:0] weight;

  modport source (output valid, output rhs_re, output rhs_im, output weight, input ready);
  modport sink (input valid, input rhs_re, input rhs_im, input weight, output ready);
endinterface

interface ctsc_out_if;
  logic                           valid;
  logic                           ready;
  logic [ctsc_pkg::ROW_W-1:0]     row_index;
  logic signed [31:0]             sol_re;
  logic signed [31:0]             sol_im;
  logic                           last_of_column;

  modport source (output valid, output row_index, output sol_re, output sol_im,
                  output last_of_column, input ready);
  modport sink (input valid, input row_index, input sol_re, input sol_im,
                input last_of_column, output ready);
endinterface

interface ctsc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ctsc_pkg::LEN_W-1:0] column_length;

  modport source (output valid, output column_length, input ready);
  modport sink (input valid, input column_length, output ready);
endinterface

// ===== design/ctsc_mulw.sv =====
`timescale 1ns / 1ps

module ctsc_mulw (
  input  logic               clk,
  input  logic               rst_n,
  input  ctsc_pkg::mul_tag_t req_tag,
  input  ctsc_pkg::data_t    op_d,
  input  ctsc_pkg::weight_t  op_w,
  output ctsc_pkg::mul_tag_t rsp_tag,
  output ctsc_pkg::data_t    res
);

  localparam logic signed [ctsc_pkg::PROD_W-1:0] HALF =
    ctsc_pkg::PROD_W'(1) <<< (ctsc_pkg::FRAC_W - 1);
  localparam logic signed [ctsc_pkg::PROD_W-1:0] DMAX_P =
    ctsc_pkg::PROD_W'(ctsc_pkg::DMAX);
  localparam logic signed [ctsc_pkg::PROD_W-1:0] DMIN_P =
    {{(ctsc_pkg::PROD_W - ctsc_pkg::DATA_WIDTH){1'b1}}, ctsc_pkg::DMIN};

  ctsc_pkg::mul_tag_t tag0_r, tag1_r, tag2_r;
  ctsc_pkg::data_t    d_r;
  ctsc_pkg::weight_t  w_r;
  logic signed [ctsc_pkg::PROD_W-1:0] prod_r;
  ctsc_pkg::data_t    res_r;

  logic signed [ctsc_pkg::PROD_W-1:0] rounded;
  logic signed [ctsc_pkg::PROD_W-1:0] quot;
  ctsc_pkg::data_t    res_nxt;

  // Round half away from zero: negative products get one less bias before the shift.
  always_comb begin
    rounded = prod_r + HALF - ctsc_pkg::PROD_W'(prod_r[ctsc_pkg::PROD_W-1]);
    quot    = rounded >>> ctsc_pkg::FRAC_W;
    if (quot > DMAX_P) begin
      res_nxt = ctsc_pkg::DMAX;
    end else if (quot < DMIN_P) begin
      res_nxt = ctsc_pkg::DMIN;
    end else begin
      res_nxt = quot[ctsc_pkg::DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag0_r <= req_tag;
      tag1_r <= tag0_r;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= op_d;
    w_r    <= op_w;
    prod_r <= d_r * w_r;
    res_r  <= res_nxt;
  end

  assign rsp_tag = tag2_r;
  assign res     = res_r;

endmodule

// ===== design/complex_tridiagonal_column_solver_core.sv =====
`timescale 1ns / 1ps

// Solves one complex tridiagonal column with unit off-diagonals, element by element.
// The in_ch channel carries one right-hand-side element and its forward weight per
// transfer; forward elimination runs as each element arrives. The cfg_ch channel
// writes column_length and is always ready; write it only while the block is idle.
// When the element that completes the column has been taken, back substitution runs
// and out_ch delivers every solution in descending row order, with last_of_column on
// row zero. One pipelined multiplier of three stages is shared by the real and the
// imaginary halves of every step, one half after the other. in_ch.ready is low while
// an element or the back substitution is in progress. A stalled receiver holds the
// output register and the back substitution waits on it; the last solution may still
// wait there while the next column's first element is taken. Reset sets
// column_length to 64, clears the running forward values and the element count, and
// empties the output register. The stores need no clearing.

module complex_tridiagonal_column_solver_core (
  input  logic              clk,
  input  logic              rst_n,
  ctsc_in_if.sink           in_ch,
  ctsc_out_if.source        out_ch,
  ctsc_cfg_if.sink          cfg_ch
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_FRE     = 9'b000000010,
    S_FIM     = 9'b000000100,
    S_FWAIT   = 9'b000001000,
    S_BREAD   = 9'b000010000,
    S_BMUL_RE = 9'b000100000,
    S_BMUL_IM = 9'b001000000,
    S_BWAIT   = 9'b010000000,
    S_BEMIT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ctsc_pkg::LEN_W-1:0] column_length_r;
  logic [ctsc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [ctsc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       first_r, first_nxt;
  ctsc_pkg::data_t            prev_re_r, prev_re_nxt, prev_im_r, prev_im_nxt;
  ctsc_pkg::data_t            b_re_r, b_im_r;
  ctsc_pkg::weight_t          w_r;
  ctsc_pkg::data_t            x_re_r, x_re_nxt, x_im_r, x_im_nxt;

  ctsc_pkg::store_entry_t store_mem [ctsc_pkg::MAX_COLUMN];
  ctsc_pkg::store_entry_t rd_r;
  logic                   wr_en;
  ctsc_pkg::store_entry_t wr_data;

  logic                       out_valid_r, out_load;
  logic [ctsc_pkg::ROW_W-1:0] out_row_r;
  ctsc_pkg::data_t            out_re_r, out_im_r;
  logic                       out_last_r;

  ctsc_pkg::mul_tag_t req_tag, rsp_tag;
  ctsc_pkg::data_t    op_d, mul_res;
  ctsc_pkg::weight_t  op_w;

  logic [ctsc_pkg::CNT_W-1:0] cnt_inc;
  logic                       column_done;

  ctsc_mulw u_mulw (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_tag (req_tag),
    .op_d    (op_d),
    .op_w    (op_w),
    .rsp_tag (rsp_tag),
    .res     (mul_res)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign cnt_inc     = count_r + ctsc_pkg::CNT_W'(1);
  assign column_done = (32'(cnt_inc) >= 32'(column_length_r)) ||
                       (32'(cnt_inc) == 32'(ctsc_pkg::MAX_COLUMN));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    first_nxt   = first_r;
    prev_re_nxt = prev_re_r;
    prev_im_nxt = prev_im_r;
    x_re_nxt    = x_re_r;
    x_im_nxt    = x_im_r;
    req_tag     = '0;
    op_d        = x_re_r;
    op_w        = rd_r.w;
    wr_en       = 1'b0;
    wr_data     = '{y_re: prev_re_r, y_im: mul_res, w: w_r};
    out_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_FRE;
        end
      end
      S_FRE: begin
        req_tag   = '{valid: 1'b1, im: 1'b0};
        op_d      = ctsc_pkg::sat_sub(b_re_r, prev_re_r);
        op_w      = w_r;
        state_nxt = S_FIM;
      end
      S_FIM: begin
        req_tag   = '{valid: 1'b1, im: 1'b1};
        op_d      = ctsc_pkg::sat_sub(b_im_r, prev_im_r);
        op_w      = w_r;
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (rsp_tag.valid && !rsp_tag.im) begin
          prev_re_nxt = mul_res;
        end
        if (rsp_tag.valid && rsp_tag.im) begin
          wr_en = 1'b1;
          if (column_done) begin
            prev_re_nxt = '0;
            prev_im_nxt = '0;
            idx_nxt     = count_r[ctsc_pkg::IDX_W-1:0];
            first_nxt   = 1'b1;
            count_nxt   = '0;
            state_nxt   = S_BREAD;
          end else begin
            prev_im_nxt = mul_res;
            count_nxt   = cnt_inc;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_BREAD: begin
        state_nxt = S_BMUL_RE;
      end
      S_BMUL_RE: begin
        if (first_r) begin
          x_re_nxt  = rd_r.y_re;
          x_im_nxt  = rd_r.y_im;
          first_nxt = 1'b0;
          state_nxt = S_BEMIT;
        end else begin
          req_tag   = '{valid: 1'b1, im: 1'b0};
          op_d      = x_re_r;
          state_nxt = S_BMUL_IM;
        end
      end
      S_BMUL_IM: begin
        req_tag   = '{valid: 1'b1, im: 1'b1};
        op_d      = x_im_r;
        state_nxt = S_BWAIT;
      end
      S_BWAIT: begin
        if (rsp_tag.valid && !rsp_tag.im) begin
          x_re_nxt = ctsc_pkg::sat_sub(rd_r.y_re, mul_res);
        end
        if (rsp_tag.valid && rsp_tag.im) begin
          x_im_nxt  = ctsc_pkg::sat_sub(rd_r.y_im, mul_res);
          state_nxt = S_BEMIT;
        end
      end
      S_BEMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - ctsc_pkg::IDX_W'(1);
            state_nxt = S_BREAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      column_length_r <= ctsc_pkg::LEN_RESET;
      count_r         <= '0;
      idx_r           <= '0;
      first_r         <= 1'b0;
      prev_re_r       <= '0;
      prev_im_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      first_r   <= first_nxt;
      prev_re_r <= prev_re_nxt;
      prev_im_r <= prev_im_nxt;
      if (cfg_ch.valid) begin
        column_length_r <= cfg_ch.column_length;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_re_r <= x_re_nxt;
    x_im_r <= x_im_nxt;
    if (in_ch.valid && in_ch.ready) begin
      b_re_r <= in_ch.rhs_re;
      b_im_r <= in_ch.rhs_im;
      w_r    <= in_ch.weight;
    end
    if (out_load) begin
      out_row_r  <= ctsc_pkg::ROW_W'(idx_r);
      out_re_r   <= x_re_r;
      out_im_r   <= x_im_r;
      out_last_r <= (idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[count_r[ctsc_pkg::IDX_W-1:0]] <= wr_data;
    end
    rd_r <= store_mem[idx_r];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.row_index      = out_row_r;
  assign out_ch.sol_re         = out_re_r;
  assign out_ch.sol_im         = out_im_r;
  assign out_ch.last_of_column = out_last_r;

endmodule

// ===== design/ctsc_checker.sv =====
`timescale 1ns / 1ps

module ctsc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ctsc_pkg::ROW_W-1:0] out_row_index,
  input logic [31:0]                out_sol_re,
  input logic [31:0]                out_sol_im,
  input logic                       out_last
);

  // The block works on one element at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an element is still in progress");

  // The last marker belongs to row zero and to no other row.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_row_index == '0)))
    else $error("last marker does not match row zero");

  // No new element is taken while a solution other than the column's last is waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of back substitution");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index) &&
      $stable(out_sol_re) && $stable(out_sol_im) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind complex_tridiagonal_column_solver_core ctsc_checker u_ctsc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_row_index (out_ch.row_index),
  .out_sol_re    (out_ch.sol_re),
  .out_sol_im    (out_ch.sol_im),
  .out_last      (out_ch.last_of_column)
);
